// ===== hw/rtl/plt_pkg.sv =====
// plt_pkg: sizes and types shared by the polygon left-turn block and its checker.
// Depends on nothing; the files that use it refer to it by scoped names.
package plt_pkg;

  localparam int MAX_POINTS = 32;
  localparam int COORD_BITS = 32;

  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int RL_W       = $clog2(MAX_POINTS + 3);

  localparam int OUT_W      = 32;
  localparam int COUNT_W    = 6;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;
  localparam int USER_W     = 2;

  // tuser bit positions on the result side
  localparam int USER_IS_VERTEX = 0;
  localparam int USER_OVERFLOW  = 1;

  typedef logic signed [COORD_BITS-1:0]       coord_t;
  typedef logic signed [COORD_BITS:0]         diff_t;
  typedef logic signed [2*COORD_BITS+1:0]     prod_t;

endpackage

// ===== hw/rtl/plt_ram.sv =====
// plt_ram: generic simple dual-port memory, one write and one registered read port.
// Depends on nothing.
module plt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/polygon_left_turn_vertices.sv =====
// channel  dir  tdata (lsb up)                          tuser (lsb up)          tlast
// s_axis   in   point_x, point_y                        -                       final_point
// m_axis   out  vertex_x, vertex_y, vertex_count, pad   is_vertex, overflowed   run_end
//
// loading takes points while no walk runs; the last point starts a ring walk over the store.
// the walk reads one vertex a cycle from the point ram while the output does not stall:
// n+2 reads (none below three points), then difference, multiply and compare, then the summary.
// an output stall freezes the whole walk pipeline, ram read register included.
// reset is synchronous and immediate; the point store needs no clearing pass.
// Top level of the polygon left-turn vertex block; uses plt_pkg and plt_ram.
module polygon_left_turn_vertices (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [plt_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // point_x, point_y
  input  logic                             s_axis_tlast,   // final_point
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [plt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // vertex_x, vertex_y, vertex_count, pad
  output logic [plt_pkg::USER_W-1:0]       m_axis_tuser,   // is_vertex, overflowed
  output logic                             m_axis_tlast    // run_end
);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state;

  // load side
  plt_pkg::coord_t            in_x, in_y;
  plt_pkg::coord_t            min_x, max_x, min_y, max_y;
  plt_pkg::coord_t            min_x_next, max_x_next, min_y_next, max_y_next;
  logic [plt_pkg::IDX_W-1:0]  start_index, start_next;
  logic [plt_pkg::CNT_W-1:0]  points_loaded, loaded_next;
  logic                       overflow_flag, ovf_next;
  logic                       s_fire, full;

  // walk side
  logic                       adv;
  logic [plt_pkg::RL_W-1:0]   rd_left;
  logic [plt_pkg::IDX_W-1:0]  rd_addr, last_addr;
  logic                       rv, dv, mv;
  logic [1:0]                 win_cnt;
  plt_pkg::coord_t            win_ax, win_ay, win_bx, win_by;
  plt_pkg::coord_t            c_x, c_y;
  plt_pkg::diff_t             d_bax, d_cay, d_bay, d_cax;
  plt_pkg::coord_t            d_bx, d_by;
  plt_pkg::prod_t             p_prod, q_prod;
  plt_pkg::coord_t            m_bx, m_by;
  logic                       left_turn, pipe_empty;
  logic [plt_pkg::CNT_W-1:0]  cnt;

  // ram
  logic                                ram_we, ram_re;
  logic [2*plt_pkg::COORD_BITS-1:0]    ram_rdata;

  // output register
  logic                                m_valid;
  plt_pkg::coord_t                     o_x, o_y;
  logic                                o_is_vertex, o_ovf, o_end;
  logic [plt_pkg::COUNT_W-1:0]         o_count;

  assign s_axis_tready = (state == ST_LOAD);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_x          = s_axis_tdata[plt_pkg::COORD_BITS-1:0];
  assign in_y          = s_axis_tdata[32 +: plt_pkg::COORD_BITS];
  assign full          = (points_loaded == plt_pkg::CNT_W'(plt_pkg::MAX_POINTS));

  // extremes, start index, point count and overflow flag for the incoming point
  always_comb begin
    min_x_next  = min_x;
    max_x_next  = max_x;
    min_y_next  = min_y;
    max_y_next  = max_y;
    start_next  = start_index;
    loaded_next = points_loaded;
    ovf_next    = overflow_flag;
    if (full) begin
      ovf_next = 1'b1;
    end else begin
      loaded_next = points_loaded + 1'b1;
      if (points_loaded == '0) begin
        min_x_next = in_x;
        max_x_next = in_x;
        min_y_next = in_y;
        max_y_next = in_y;
        start_next = '0;
      end else begin
        if (in_x < min_x) begin
          min_x_next = in_x;
          start_next = points_loaded[plt_pkg::IDX_W-1:0];
        end
        if (in_x > max_x) begin
          max_x_next = in_x;
          start_next = points_loaded[plt_pkg::IDX_W-1:0];
        end
        if (in_y < min_y) begin
          min_y_next = in_y;
          start_next = points_loaded[plt_pkg::IDX_W-1:0];
        end
        if (in_y > max_y) begin
          max_y_next = in_y;
          start_next = points_loaded[plt_pkg::IDX_W-1:0];
        end
      end
    end
  end

  // loading and walking never overlap, so a read never meets a pending write
  assign ram_we = s_fire && !full;

  assign adv        = !m_valid || m_axis_tready;
  assign ram_re     = (state == ST_WALK) && adv && (rd_left != '0);
  assign last_addr  = plt_pkg::IDX_W'(points_loaded - 1'b1);
  assign c_x        = ram_rdata[plt_pkg::COORD_BITS-1:0];
  assign c_y        = ram_rdata[2*plt_pkg::COORD_BITS-1:plt_pkg::COORD_BITS];
  assign left_turn  = (p_prod > q_prod);
  assign pipe_empty = (rd_left == '0) && !rv && !dv && !mv;

  plt_ram #(
    .WIDTH (2 * plt_pkg::COORD_BITS),
    .DEPTH (plt_pkg::MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (points_loaded[plt_pkg::IDX_W-1:0]),
    .wdata ({in_y, in_x}),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      points_loaded <= '0;
      overflow_flag <= 1'b0;
      start_index   <= '0;
      rd_left       <= '0;
      rd_addr       <= '0;
      rv            <= 1'b0;
      dv            <= 1'b0;
      mv            <= 1'b0;
      win_cnt       <= '0;
      cnt           <= '0;
      m_valid       <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (m_axis_tready) begin
            m_valid <= 1'b0;
          end
          if (s_fire) begin
            min_x         <= min_x_next;
            max_x         <= max_x_next;
            min_y         <= min_y_next;
            max_y         <= max_y_next;
            start_index   <= start_next;
            points_loaded <= loaded_next;
            overflow_flag <= ovf_next;
            if (s_axis_tlast) begin
              state   <= ST_WALK;
              rd_addr <= start_next;
              win_cnt <= '0;
              cnt     <= '0;
              // a, b, then one c per vertex
              if (loaded_next >= plt_pkg::CNT_W'(3)) begin
                rd_left <= plt_pkg::RL_W'(loaded_next) + plt_pkg::RL_W'(2);
              end else begin
                rd_left <= '0;
              end
            end
          end
        end
        ST_WALK: begin
          if (adv) begin
            if (rd_left != '0) begin
              rd_left <= rd_left - 1'b1;
              rd_addr <= (rd_addr == last_addr) ? '0 : rd_addr + 1'b1;
            end
            rv <= (rd_left != '0);

            // sliding window over the ring; the first two words only prime it
            if (rv) begin
              win_ax <= win_bx;
              win_ay <= win_by;
              win_bx <= c_x;
              win_by <= c_y;
              if (win_cnt != 2'd2) begin
                win_cnt <= win_cnt + 1'b1;
              end
            end
            dv    <= rv && (win_cnt == 2'd2);
            d_bax <= plt_pkg::diff_t'(win_bx) - plt_pkg::diff_t'(win_ax);
            d_cay <= plt_pkg::diff_t'(c_y)    - plt_pkg::diff_t'(win_ay);
            d_bay <= plt_pkg::diff_t'(win_by) - plt_pkg::diff_t'(win_ay);
            d_cax <= plt_pkg::diff_t'(c_x)    - plt_pkg::diff_t'(win_ax);
            d_bx  <= win_bx;
            d_by  <= win_by;

            mv     <= dv;
            p_prod <= d_bax * d_cay;
            q_prod <= d_bay * d_cax;
            m_bx   <= d_bx;
            m_by   <= d_by;

            if (mv && left_turn) begin
              m_valid     <= 1'b1;
              o_x         <= m_bx;
              o_y         <= m_by;
              o_is_vertex <= 1'b1;
              o_count     <= '0;
              o_ovf       <= overflow_flag;
              o_end       <= 1'b0;
              cnt         <= cnt + 1'b1;
            end else if (pipe_empty) begin
              m_valid       <= 1'b1;
              o_x           <= '0;
              o_y           <= '0;
              o_is_vertex   <= 1'b0;
              o_count       <= plt_pkg::COUNT_W'(cnt);
              o_ovf         <= overflow_flag;
              o_end         <= 1'b1;
              state         <= ST_LOAD;
              points_loaded <= '0;
              overflow_flag <= 1'b0;
              start_index   <= '0;
            end else begin
              m_valid <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {2'b00, o_count, plt_pkg::OUT_W'(o_y), plt_pkg::OUT_W'(o_x)};
  assign m_axis_tuser  = {o_ovf, o_is_vertex};
  assign m_axis_tlast  = o_end;

endmodule

// ===== hw/rtl/plt_checker.sv =====
// plt_checker: port-level assertions for polygon_left_turn_vertices, attached by bind.
// Depends on plt_pkg for port widths and tuser bit positions.
module plt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [plt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [plt_pkg::USER_W-1:0]       m_axis_tuser,
  input logic                             m_axis_tlast
);

  // summary word is the only one with run_end and never a vertex
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == !m_axis_tuser[plt_pkg::USER_IS_VERTEX]))
    else $error("run_end and is_vertex disagree");

  // vertex words carry no count
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[plt_pkg::USER_IS_VERTEX] |->
      (m_axis_tdata[64 +: plt_pkg::COUNT_W] == '0))
    else $error("vertex word with nonzero count");

  // the last point of a polygon stops intake for the walk
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("point taken during ring walk");

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed under stall");

endmodule

bind polygon_left_turn_vertices plt_checker u_plt_checker (.*);

// ===== bench/tb_polygon_left_turn_vertices.sv =====
// tb_polygon_left_turn_vertices: stream bench for the polygon left-turn block; a scoreboard
// class predicts vertex and summary words per polygon and checks them in order.
// Depends on plt_pkg and polygon_left_turn_vertices.
module tb_polygon_left_turn_vertices;

  typedef logic signed [63:0] field_t;
  typedef logic signed [67:0] wide_t;

  typedef struct {
    plt_pkg::coord_t                vx;
    plt_pkg::coord_t                vy;
    logic                           is_vertex;
    logic [plt_pkg::COUNT_W-1:0]    count;
    logic                           overflowed;
    logic                           run_end;
  } vertex_word_t;

  typedef enum int {SPREAD_TIGHT, SPREAD_FULL, SPREAD_CORNERS, SPREAD_MIXED} spread_t;

  class polygon_scoreboard;
    plt_pkg::coord_t ring_x[plt_pkg::MAX_POINTS];
    plt_pkg::coord_t ring_y[plt_pkg::MAX_POINTS];
    plt_pkg::coord_t lo_x, hi_x, lo_y, hi_y;
    int unsigned     head_idx;
    int unsigned     stored;
    bit              dropped;
    vertex_word_t    pending_words[$];
    int              errors, vertex_words, summary_words, overflow_runs, points, polygons;

    function bit turns_left(int unsigned ia, int unsigned ib, int unsigned ic);
      wide_t ax, ay, bx, by, cx, cy, det;
      ax = ring_x[ia]; ay = ring_y[ia];
      bx = ring_x[ib]; by = ring_y[ib];
      cx = ring_x[ic]; cy = ring_y[ic];
      det = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      return det > 0;
    endfunction

    function void note_point(plt_pkg::coord_t x, plt_pkg::coord_t y, bit last_pt);
      vertex_word_t w;
      int unsigned  a, b, c, cnt;
      points++;
      if (stored >= plt_pkg::MAX_POINTS) begin
        dropped = 1'b1;
      end else begin
        if (stored == 0) begin
          lo_x = x; hi_x = x; lo_y = y; hi_y = y;
          head_idx = 0;
        end else begin
          // only a strictly new extreme moves the walk start
          if (x < lo_x) begin lo_x = x; head_idx = stored; end
          if (x > hi_x) begin hi_x = x; head_idx = stored; end
          if (y < lo_y) begin lo_y = y; head_idx = stored; end
          if (y > hi_y) begin hi_y = y; head_idx = stored; end
        end
        ring_x[stored] = x;
        ring_y[stored] = y;
        stored++;
      end
      if (!last_pt) return;
      cnt = 0;
      if (stored >= 3) begin
        a = head_idx;
        b = (a + 1) % stored;
        c = (b + 1) % stored;
        repeat (stored) begin
          if (turns_left(a, b, c)) begin
            w.vx = ring_x[b];
            w.vy = ring_y[b];
            w.is_vertex = 1'b1;
            w.count = '0;
            w.overflowed = dropped;
            w.run_end = 1'b0;
            pending_words = {pending_words, w};
            cnt++;
          end
          a = b;
          b = c;
          c = (c + 1) % stored;
        end
      end
      w.vx = '0;
      w.vy = '0;
      w.is_vertex = 1'b0;
      w.count = cnt[plt_pkg::COUNT_W-1:0];
      w.overflowed = dropped;
      w.run_end = 1'b1;
      pending_words = {pending_words, w};
      if (dropped) overflow_runs++;
      polygons++;
      stored = 0;
      dropped = 1'b0;
      head_idx = 0;
      lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
    endfunction

    function void compare_field(string name, field_t want, field_t got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_record(vertex_word_t got);
      vertex_word_t want;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word x=%0d y=%0d is_vertex=%0b run_end=%0b",
                 $time, got.vx, got.vy, got.is_vertex, got.run_end);
        return;
      end
      want = pending_words.pop_front();
      compare_field("vertex_x", want.vx, got.vx);
      compare_field("vertex_y", want.vy, got.vy);
      compare_field("is_vertex", {63'd0, want.is_vertex}, {63'd0, got.is_vertex});
      compare_field("vertex_count", {58'd0, want.count}, {58'd0, got.count});
      compare_field("overflowed", {63'd0, want.overflowed}, {63'd0, got.overflowed});
      compare_field("run_end", {63'd0, want.run_end}, {63'd0, got.run_end});
      if (want.run_end) summary_words++;
      else vertex_words++;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_valid = 1'b0;
  logic                               s_ready;
  logic [plt_pkg::IN_DATA_W-1:0]      s_data = '0;
  logic                               s_last = 1'b0;
  logic                               m_valid;
  logic                               m_ready = 1'b0;
  logic [plt_pkg::OUT_DATA_W-1:0]     m_data;
  logic [plt_pkg::USER_W-1:0]         m_user;
  logic                               m_last;
  bit                                 steady = 1'b0;

  polygon_scoreboard sb = new;

  polygon_left_turn_vertices i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),   // point_x, point_y
    .s_axis_tlast  (s_last),   // final_point
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),   // vertex_x, vertex_y, vertex_count, pad
    .m_axis_tuser  (m_user),   // is_vertex, overflowed
    .m_axis_tlast  (m_last)    // run_end
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic plt_pkg::coord_t pick_coord(spread_t spread);
    case (spread)
      SPREAD_TIGHT: return plt_pkg::coord_t'(int'($urandom_range(0, 16)) - 8);
      SPREAD_FULL:  return plt_pkg::coord_t'($urandom);
      default: begin
        case ($urandom_range(0, 6))
          0:       return plt_pkg::coord_t'(32'h8000_0000);
          1:       return plt_pkg::coord_t'(32'h7fff_ffff);
          2:       return plt_pkg::coord_t'(32'h8000_0001);
          3:       return plt_pkg::coord_t'(32'h7fff_fffe);
          4:       return plt_pkg::coord_t'(32'hffff_ffff);
          5:       return plt_pkg::coord_t'(32'h0000_0001);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // result side: ready in bursts, stalls of random length unless steady
  initial begin
    int run_len, stall_len;
    forever begin
      m_ready = 1'b1;
      run_len = $urandom_range(1, 10);
      repeat (run_len) @(negedge clk);
      stall_len = steady ? 0 : pick_gap();
      if (stall_len > 0) begin
        m_ready = 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    vertex_word_t got;
    if (!rst && m_valid && m_ready) begin
      got.vx = m_data[31:0];
      got.vy = m_data[63:32];
      got.count = m_data[64 +: plt_pkg::COUNT_W];
      got.is_vertex = m_user[plt_pkg::USER_IS_VERTEX];
      got.overflowed = m_user[plt_pkg::USER_OVERFLOW];
      got.run_end = m_last;
      sb.check_record(got);
    end
  end

  task automatic send_point(plt_pkg::coord_t x, plt_pkg::coord_t y, bit last_pt);
    int gap;
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid = 1'b1;
    s_data = {y, x};
    s_last = last_pt;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_point(x, y, last_pt);
  endtask

  task automatic send_polygon(int size, spread_t spread);
    spread_t s;
    for (int i = 0; i < size; i++) begin
      s = (spread == SPREAD_MIXED) ? spread_t'($urandom_range(0, 2)) : spread;
      send_point(pick_coord(s), pick_coord(s), i == size - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    plt_pkg::coord_t lo, hi;
    int random_points, poly, size;
    lo = plt_pkg::coord_t'(32'h8000_0000);
    hi = plt_pkg::coord_t'(32'h7fff_ffff);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // counterclockwise triangle: every vertex turns left
    send_point(0, 0, 0); send_point(4, 0, 0); send_point(0, 4, 1);
    // clockwise triangle: none does
    send_point(0, 0, 0); send_point(0, 4, 0); send_point(4, 0, 1);
    // lone point and a pair give only the summary word
    send_point(hi, lo, 1);
    send_point(lo, hi, 0); send_point(hi, lo, 1);
    // collinear, zero determinant
    send_point(0, 0, 0); send_point(1, 1, 0); send_point(2, 2, 1);
    // full-range squares, both windings
    send_point(lo, lo, 0); send_point(hi, lo, 0); send_point(hi, hi, 0); send_point(lo, hi, 1);
    send_point(lo, lo, 0); send_point(lo, hi, 0); send_point(hi, hi, 0); send_point(hi, lo, 1);
    // repeated extremes must not move the walk start
    send_point(0, 0, 0); send_point(0, 0, 0); send_point(5, 0, 0); send_point(5, 5, 0);
    send_point(5, 5, 1);
    wait_drained();

    random_points = 0;
    poly = 0;
    while (random_points < 105) begin
      case (poly)
        1:       size = plt_pkg::MAX_POINTS;
        3:       size = plt_pkg::MAX_POINTS + 3;
        6:       size = plt_pkg::MAX_POINTS + 1;
        default: size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
      endcase
      steady = ($urandom_range(0, 4) == 0);
      if (poly == 4) wait_drained();
      send_polygon(size, spread_t'($urandom_range(0, 3)));
      random_points += size;
      poly++;
    end
    steady = 1'b0;
    wait_drained();
    repeat (48) @(posedge clk);

    $display("covered %0d points in %0d polygons, %0d of them past capacity",
             sb.points, sb.polygons, sb.overflow_runs);
    $display("checked %0d vertex words and %0d summary words", sb.vertex_words,
             sb.summary_words);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_polygon_left_turn_vertices: PASS");
    end else begin
      $display("tb_polygon_left_turn_vertices: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_polygon_left_turn_vertices: FAIL");
    $finish;
  end

endmodule
